FILE: design/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg
// shared widths, types and helpers for the triangle max path sum block
// ----------------------------------------------------------------------------
package tmps_pkg;

  localparam int unsigned MAX_ROWS = 1024;

  localparam int unsigned ENTRY_W  = 16;
  localparam int unsigned RC_W     = 11;
  localparam int unsigned TOTAL_W  = 26;

  localparam longint unsigned ENTRY_MAX = (64'd1 << ENTRY_W) - 64'd1;
  localparam longint unsigned SUM_MAX   = longint'(MAX_ROWS) * ENTRY_MAX;

  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 64'd1);
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMP_W   = (ROW_W > RC_W) ? ROW_W : RC_W;
  localparam int unsigned CNT_W   = ROW_W;
  localparam int unsigned WIDE_W  = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

  localparam int unsigned IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((TOTAL_W + 7) / 8) * 8;

  localparam logic [WIDE_W-1:0] TOTAL_MAX = WIDE_W'((64'd1 << TOTAL_W) - 64'd1);

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [TOTAL_W-1:0] sat_total(input sum_t s);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(s);
    if (w > TOTAL_MAX) begin
      w = TOTAL_MAX;
    end
    return w[TOTAL_W-1:0];
  endfunction

endpackage

FILE: design/tmps_cell.sv
// ----------------------------------------------------------------------------
// tmps_cell
// one slot of the row buffer: loads a new sum or takes its neighbor's
// ----------------------------------------------------------------------------
module tmps_cell (
  input  logic                clk_i,
  input  tmps_pkg::cell_ctrl_t ctrl_i,
  input  tmps_pkg::sum_t      load_i,
  input  tmps_pkg::sum_t      nbr_i,
  output tmps_pkg::sum_t      val_o
);

  tmps_pkg::sum_t val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.load) begin
      val_d = load_i;
    end else if (ctrl_i.shift) begin
      val_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

FILE: design/tmps_row_buf.sv
// ----------------------------------------------------------------------------
// tmps_row_buf
// row of best sums as a chain of cells shifting toward the head, fill count
// ----------------------------------------------------------------------------
module tmps_row_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           beat_i,
  input  logic           pop_i,
  input  logic           flush_i,
  input  tmps_pkg::sum_t push_i,
  output tmps_pkg::sum_t head_o
);

  logic [tmps_pkg::CNT_W-1:0] count_q, count_d;
  logic [tmps_pkg::CNT_W-1:0] wr_idx;
  tmps_pkg::sum_t             cell_val [tmps_pkg::MAX_ROWS];

  assign wr_idx = pop_i ? (count_q - tmps_pkg::CNT_W'(1)) : count_q;

  for (genvar g = 0; g < tmps_pkg::MAX_ROWS; g++) begin : g_cell
    tmps_pkg::cell_ctrl_t ctrl;
    tmps_pkg::sum_t       nbr;

    assign ctrl.load  = beat_i && (wr_idx == tmps_pkg::CNT_W'(g));
    assign ctrl.shift = beat_i && pop_i;

    if (g == tmps_pkg::MAX_ROWS - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_val[g+1];
    end

    tmps_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .load_i (push_i),
      .nbr_i  (nbr),
      .val_o  (cell_val[g])
    );
  end

  assign head_o = cell_val[0];

  always_comb begin
    count_d = count_q;
    if (beat_i) begin
      if (flush_i) begin
        count_d = '0;
      end else if (!pop_i) begin
        count_d = count_q + tmps_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && pop_i |-> count_q != '0)
    else $error("row buffer popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tmps_pkg::CNT_W'(tmps_pkg::MAX_ROWS))
    else $error("row buffer fill beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && !pop_i && !flush_i |=> count_q == $past(count_q) + tmps_pkg::CNT_W'(1))
    else $error("row buffer fill did not grow on push");

endmodule

FILE: design/triangle_max_path_sum.sv
// ----------------------------------------------------------------------------
// triangle_max_path_sum
// streaming maximum path sum over a number triangle, one entry per beat
// ----------------------------------------------------------------------------
// Entries arrive row by row, left to right, one per cycle while ready is high,
// with no gaps required; row_count sets the rows per triangle (0 acts as 1,
// values above the buffer depth are clamped). The previous row's best sums
// sit in a chain of 1024 cells that shifts one place toward the head on each
// entry that consumes an upper parent, so the buffer never holds up an entry.
// The total for a triangle is registered from its last entry and holds until
// taken; only a final entry waits for the output slot, all others are
// accepted while a total is pending. No clearing pass after reset.
module triangle_max_path_sum (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tmps_pkg::RC_W-1:0]          cfg_wdata_i,   // row_count
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tmps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // entry_value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tmps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // best_total, zero pad
);

  logic [tmps_pkg::RC_W-1:0]    row_count_q;
  logic [tmps_pkg::ROW_W-1:0]   row_q, row_d, col_q, col_d;
  tmps_pkg::sum_t               ul_q, ul_d, best_q, best_d;
  logic                         out_valid_q, out_valid_d;
  logic [tmps_pkg::TOTAL_W-1:0] out_data_q, out_data_d;

  logic [tmps_pkg::CMP_W-1:0]   eff_rows;
  logic                         last_row, row_end, final_pos, beat, pop;
  tmps_pkg::sum_t               head, up, left, cell_sum, best_new;

  always_comb begin
    eff_rows = tmps_pkg::CMP_W'(row_count_q);
    if (row_count_q == '0) begin
      eff_rows = tmps_pkg::CMP_W'(1);
    end else if (eff_rows > tmps_pkg::CMP_W'(tmps_pkg::MAX_ROWS)) begin
      eff_rows = tmps_pkg::CMP_W'(tmps_pkg::MAX_ROWS);
    end
  end

  assign last_row  = tmps_pkg::CMP_W'(row_q) >= eff_rows;
  assign row_end   = col_q >= row_q;
  assign final_pos = row_end && last_row;
  assign pop       = col_q < row_q;

  assign s_axis_tready = !final_pos || !out_valid_q || m_axis_tready;
  assign beat          = s_axis_tvalid && s_axis_tready;

  assign up       = pop ? head : '0;
  assign left     = (col_q > tmps_pkg::ROW_W'(1)) ? ul_q : '0;
  assign cell_sum = ((up > left) ? up : left)
                  + tmps_pkg::SUM_W'(s_axis_tdata[tmps_pkg::ENTRY_W-1:0]);
  assign best_new = (last_row && (cell_sum > best_q)) ? cell_sum : best_q;

  tmps_row_buf u_row_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .pop_i   (pop),
    .flush_i (final_pos),
    .push_i  (cell_sum),
    .head_o  (head)
  );

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    ul_d        = ul_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (beat) begin
      ul_d   = up;
      best_d = best_new;
      if (final_pos) begin
        out_valid_d = 1'b1;
        out_data_d  = tmps_pkg::sat_total(best_new);
        row_d       = tmps_pkg::ROW_W'(1);
        col_d       = tmps_pkg::ROW_W'(1);
        ul_d        = '0;
        best_d      = '0;
      end else if (row_end) begin
        row_d = row_q + tmps_pkg::ROW_W'(1);
        col_d = tmps_pkg::ROW_W'(1);
        ul_d  = '0;
      end else begin
        col_d = col_q + tmps_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= tmps_pkg::RC_W'(1);
      row_q       <= tmps_pkg::ROW_W'(1);
      col_q       <= tmps_pkg::ROW_W'(1);
      ul_q        <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        row_count_q <= cfg_wdata_i;
      end
      row_q       <= row_d;
      col_q       <= col_d;
      ul_q        <= ul_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tmps_pkg::OUT_TDATA_W'(out_data_q);

  a_final_gives_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && final_pos |=> m_axis_tvalid)
    else $error("final entry did not raise a total");

  a_col_within_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= row_q && col_q != '0)
    else $error("column position outside its row");

  a_restart_after_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && final_pos |=> row_q == tmps_pkg::ROW_W'(1) && best_q == '0)
    else $error("triangle not restarted after its total");

endmodule
